// ===== rtl/core/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the sensor frame decoder
// Field widths, centroid weight function and the divider request bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

   localparam int IdWidth    = 29;
   localparam int SensorBits = 16;
   localparam int IdxWidth   = $clog2(SensorBits);
   localparam int CountWidth = $clog2(SensorBits) + 1;
   localparam int AccWidth   = 12;   // +/- 16 * 127 fits
   localparam int PosWidth   = 8;

   // configuration register indexes
   localparam logic [1:0] CSR_HEARTBEAT_ID = 2'd0;
   localparam logic [1:0] CSR_RANGING_ID   = 2'd1;
   localparam logic [1:0] CSR_LINE_ID      = 2'd2;

   typedef struct packed {
      logic                       start;
      logic signed [AccWidth-1:0] dividend;
      logic [CountWidth-1:0]      divisor;
   } div_req_type;

   // upper half: 16*(i-7)-1 (15..127), lower half: 1-16*(8-i) (-127..-15)
   function automatic logic signed [PosWidth-1:0] bit_weight(input logic [IdxWidth-1:0] i);
      logic signed [PosWidth:0] w;
      if (i[IdxWidth-1]) begin
         w = $signed({1'b0, i - 4'd7, 4'b0000}) - 9'sd1;
      end else begin
         w = 9'sd1 - $signed({1'b0, 4'd8 - i, 4'b0000});
      end
      return w[PosWidth-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sfd_divider.sv =====
// ----------------------------------------------------------------------------
// sfd_divider: iterative signed-by-unsigned divider
// Restoring division on magnitudes, one quotient bit per cycle, truncates
// toward zero. Divisor must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire sfd_pkg::div_req_type             div_req,
   output logic                                  div_done,
   output logic signed [sfd_pkg::PosWidth-1:0]   div_quotient
);
   import sfd_pkg::*;

   localparam int MagWidth = AccWidth - 1;
   localparam int RemWidth = CountWidth - 1;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    neg_ff, neg_in;
   logic [3:0]              step_ff, step_in;
   logic [MagWidth-1:0]     quo_ff, quo_in;
   logic [RemWidth-1:0]     rem_ff, rem_in;
   logic [CountWidth-1:0]   dvs_ff, dvs_in;

   logic [CountWidth-1:0]   trial;
   logic [CountWidth-1:0]   trial_diff;
   logic [AccWidth-1:0]     mag_full;
   logic [MagWidth-1:0]     quo_neg;

   assign trial      = {rem_ff, quo_ff[MagWidth-1]};
   assign trial_diff = trial - dvs_ff;
   assign mag_full   = div_req.dividend[AccWidth-1] ? -div_req.dividend : div_req.dividend;
   assign quo_neg    = -quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.dividend[AccWidth-1];
         step_in = 4'(MagWidth - 1);
         quo_in  = mag_full[MagWidth-1:0];
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= dvs_ff) begin
            rem_in = trial_diff[RemWidth-1:0];
            quo_in = {quo_ff[MagWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[RemWidth-1:0];
            quo_in = {quo_ff[MagWidth-2:0], 1'b0};
         end
         step_in = step_ff - 4'd1;
         if (step_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = neg_ff ? $signed(quo_neg[PosWidth-1:0])
                                : $signed(quo_ff[PosWidth-1:0]);

endmodule

`default_nettype wire

// ===== rtl/core/sensor_frame_decoder_line_centroid.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_decoder_line_centroid: bus frame decoder with line centroid
// Decodes ranging sensor and line sensor frames, reports status and the
// weighted centroid of the active line sensor bits.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one received frame (identifier + 8 payload bytes) per item,
//            taken when req_valid is high and req_stall is low.
//   rsp_*  : one status item per frame, taken when rsp_valid is high and
//            rsp_stall is low. The item is held stable while stalled.
//   csr_*  : write-only identifier registers (0 heartbeat, 1 ranging data,
//            2 line sensor); index 3 is ignored. Write only while idle.
// Timing:
//   A frame with active line bits passes from accept to rsp_valid through
//   the scan of the line bits with one shared adder, a setup state, the
//   bit-serial divider, and the done state that lands the result in the
//   output register. With no active bit the divide is skipped. A new frame
//   is taken only once the sequencer is back in idle, so the scan and
//   divide loops set the throughput.
//   A new frame may be taken while the previous result is still stalled
//   on rsp; its result then waits in the final state until rsp drains.
// Reset: all status cleared, line bits all ones (no sensor active), ids 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_decoder_line_centroid (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration
   input  wire logic                               csr_wr_en,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [sfd_pkg::IdWidth-1:0]        csr_wr_data,
   // frame input
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [sfd_pkg::IdWidth-1:0]        req_frame_id,
   input  wire logic [7:0]                         req_data_byte_0,
   input  wire logic [7:0]                         req_data_byte_1,
   input  wire logic [7:0]                         req_data_byte_2,
   input  wire logic [7:0]                         req_data_byte_3,
   input  wire logic [7:0]                         req_data_byte_4,
   input  wire logic [7:0]                         req_data_byte_5,
   input  wire logic [7:0]                         req_data_byte_6,
   input  wire logic [7:0]                         req_data_byte_7,
   // status output
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_ranger_ready,
   output logic                                    rsp_ranger_fault,
   output logic [15:0]                             rsp_obstacle_distance,
   output logic [7:0]                              rsp_obstacle_angle,
   output logic                                    rsp_obstacle_present,
   output logic                                    rsp_tape_present,
   output logic [sfd_pkg::CountWidth-1:0]          rsp_active_sensor_count,
   output logic signed [sfd_pkg::PosWidth-1:0]     rsp_line_position
);
   import sfd_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   // id registers
   logic [IdWidth-1:0]  hb_id_ff, rng_id_ff, line_id_ff;

   // sensor status
   logic                ready_ff, fault_ff, obst_ff;
   logic [15:0]         dist_ff;
   logic [7:0]          angle_ff;
   logic [SensorBits-1:0] line_bits_ff;

   // sequencer
   logic [2:0]          state_ff, state_in;
   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic signed [AccWidth-1:0] acc_ff, acc_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic signed [PosWidth-1:0] pos_ff, pos_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_ready_ff, out_fault_ff, out_obst_ff, out_tape_ff;
   logic [15:0]         out_dist_ff;
   logic [7:0]          out_angle_ff;
   logic [CountWidth-1:0] out_cnt_ff;
   logic signed [PosWidth-1:0] out_pos_ff;

   logic                req_take;
   logic                out_load;
   logic                hit_hb, hit_rng, hit_line;
   div_req_type         div_req;
   logic                div_done;
   logic signed [PosWidth-1:0] div_quotient;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign hit_hb    = (req_frame_id == hb_id_ff);
   assign hit_rng   = (req_frame_id == rng_id_ff);
   assign hit_line  = (req_frame_id == line_id_ff);
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hb_id_ff   <= '0;
         rng_id_ff  <= '0;
         line_id_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HEARTBEAT_ID: hb_id_ff   <= csr_wr_data;
            CSR_RANGING_ID:   rng_id_ff  <= csr_wr_data;
            CSR_LINE_ID:      line_id_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // frame decode: heartbeat, then data, then line
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= 1'b0;
         fault_ff     <= 1'b0;
         obst_ff      <= 1'b0;
         dist_ff      <= '0;
         angle_ff     <= '0;
         line_bits_ff <= '1;
      end else if (req_take) begin
         ready_ff <= hit_hb;
         if (hit_hb) begin
            fault_ff <= req_data_byte_1[5];
         end
         if (hit_rng) begin
            dist_ff  <= {req_data_byte_1, req_data_byte_0};
            angle_ff <= req_data_byte_3;
            obst_ff  <= (req_data_byte_7 == 8'h01);
         end
         if (hit_line) begin
            line_bits_ff <= {req_data_byte_1, req_data_byte_0};
         end
      end
   end

   // sequencer: scan bits with one adder, then divide
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      div_req  = '{start: 1'b0, dividend: acc_ff, divisor: cnt_ff};
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SCAN;
               idx_in   = '0;
               acc_in   = '0;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            if (!line_bits_ff[idx_ff]) begin   // active low
               acc_in = acc_ff + AccWidth'(bit_weight(idx_ff));
               cnt_in = cnt_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IdxWidth'(SensorBits - 1)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (cnt_ff == '0) begin
               pos_in   = '0;
               state_in = ST_DONE;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               pos_in   = div_quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      pos_ff <= pos_in;
   end

   sfd_divider u_div (
      .clock        (clock),
      .reset        (reset),
      .div_req      (div_req),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         out_ready_ff <= ready_ff;
         out_fault_ff <= fault_ff;
         out_dist_ff  <= dist_ff;
         out_angle_ff <= angle_ff;
         out_obst_ff  <= obst_ff;
         out_tape_ff  <= (cnt_ff != '0);
         out_cnt_ff   <= cnt_ff;
         out_pos_ff   <= pos_ff;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_ranger_ready        = out_ready_ff;
   assign rsp_ranger_fault        = out_fault_ff;
   assign rsp_obstacle_distance   = out_dist_ff;
   assign rsp_obstacle_angle      = out_angle_ff;
   assign rsp_obstacle_present    = out_obst_ff;
   assign rsp_tape_present        = out_tape_ff;
   assign rsp_active_sensor_count = out_cnt_ff;
   assign rsp_line_position       = out_pos_ff;

endmodule

`default_nettype wire

// ===== tb/sfd_status_checker.sv =====
// ----------------------------------------------------------------------------
// sfd_status_checker: status predictor and scoreboard for the frame decoder
// Tracks identifier writes and accepted frames, predicts the status item for
// each frame and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module sfd_status_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [1:0]                           csr_index,
   input  logic [sfd_pkg::IdWidth-1:0]          csr_wr_data,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [sfd_pkg::IdWidth-1:0]          req_frame_id,
   input  logic [7:0]                           req_data_byte_0,
   input  logic [7:0]                           req_data_byte_1,
   input  logic [7:0]                           req_data_byte_3,
   input  logic [7:0]                           req_data_byte_7,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic                                 rsp_ranger_ready,
   input  logic                                 rsp_ranger_fault,
   input  logic [15:0]                          rsp_obstacle_distance,
   input  logic [7:0]                           rsp_obstacle_angle,
   input  logic                                 rsp_obstacle_present,
   input  logic                                 rsp_tape_present,
   input  logic [sfd_pkg::CountWidth-1:0]       rsp_active_sensor_count,
   input  logic signed [sfd_pkg::PosWidth-1:0]  rsp_line_position,
   output int                                   fail_count,
   output int                                   pending_count
);
   import sfd_pkg::*;

   localparam int MaxReports = 50;

   typedef struct packed {
      logic                       ready;
      logic                       fault;
      logic [15:0]                distance;
      logic [7:0]                 angle;
      logic                       present;
      logic                       tape;
      logic [CountWidth-1:0]      count;
      logic signed [PosWidth-1:0] position;
   } status_type;

   // identifier registers and decoder state as the block should hold them
   logic [IdWidth-1:0] heartbeat_id, ranging_id, line_id;
   logic               ready_st, fault_st, obstacle_st;
   logic [15:0]        distance_st, line_bits_st;
   logic [7:0]         angle_st;

   status_type status_q[$];
   int         errors = 0;

   assign fail_count = errors;

   task automatic report(input string what, input int want, input int got);
      errors++;
      if (errors <= MaxReports)
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got)
         report(what, want, got);
   endtask

   // apply one frame to the tracked state and work out its status item
   task automatic predict_status(input logic [IdWidth-1:0] id, input logic [7:0] b0,
                                 input logic [7:0] b1, input logic [7:0] b3,
                                 input logic [7:0] b7, output status_type st);
      int acc;
      int cnt;
      acc = 0;
      cnt = 0;
      ready_st = (id == heartbeat_id);
      if (ready_st)
         fault_st = b1[5];
      if (id == ranging_id) begin
         distance_st = {b1, b0};
         angle_st    = b3;
         obstacle_st = (b7 == 8'd1);
      end
      if (id == line_id)
         line_bits_st = {b1, b0};
      // active-low bits; upper half weighs 15..127, lower half -127..-15
      for (int i = 0; i < SensorBits; i++) begin
         if (!line_bits_st[i]) begin
            cnt++;
            acc += (i >= SensorBits / 2) ? 16 * (i - 7) - 1 : 1 - 16 * (8 - i);
         end
      end
      st.ready    = ready_st;
      st.fault    = fault_st;
      st.distance = distance_st;
      st.angle    = angle_st;
      st.present  = obstacle_st;
      st.tape     = (cnt > 0);
      st.count    = cnt[CountWidth-1:0];
      st.position = (cnt > 0) ? PosWidth'(acc / cnt) : '0;
   endtask

   always @(posedge clock) begin
      status_type st;
      if (reset) begin
         heartbeat_id = '0;
         ranging_id   = '0;
         line_id      = '0;
         ready_st     = 1'b0;
         fault_st     = 1'b0;
         distance_st  = '0;
         angle_st     = '0;
         obstacle_st  = 1'b0;
         line_bits_st = 16'hFFFF;
         status_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_HEARTBEAT_ID: heartbeat_id = csr_wr_data;
               CSR_RANGING_ID:   ranging_id   = csr_wr_data;
               CSR_LINE_ID:      line_id      = csr_wr_data;
               default:          ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (status_q.size() == 0) begin
               report("unexpected status item, pending", 0, 1);
            end else begin
               st = status_q.pop_front();
               check_field("ranger_ready", st.ready, rsp_ranger_ready);
               check_field("ranger_fault", st.fault, rsp_ranger_fault);
               check_field("obstacle_distance", st.distance, rsp_obstacle_distance);
               check_field("obstacle_angle", st.angle, rsp_obstacle_angle);
               check_field("obstacle_present", st.present, rsp_obstacle_present);
               check_field("tape_present", st.tape, rsp_tape_present);
               check_field("active_sensor_count", st.count, rsp_active_sensor_count);
               check_field("line_position", int'(st.position), int'(rsp_line_position));
            end
         end
         if (req_valid && !req_stall) begin
            predict_status(req_frame_id, req_data_byte_0, req_data_byte_1,
                           req_data_byte_3, req_data_byte_7, st);
            status_q.push_back(st);
         end
      end
      pending_count <= status_q.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for sensor_frame_decoder_line_centroid
// Drives frames in random bursts against a randomly stalling receiver over
// several identifier settings; a checker beside the block predicts every
// status item and the top reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import sfd_pkg::*;

   // index 3 has no register behind it; writes there must be dropped
   localparam logic [1:0] CSR_SPARE_IDX = 2'd3;
   // drain slack after the last item, covering scan and divide of one frame
   localparam int DrainCycles = 40;

   typedef struct packed {
      logic [IdWidth-1:0] id;
      logic [7:0][7:0]    data;
   } frame_type;

   // clock, reset, and every block input known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [1:0]           csr_index = CSR_HEARTBEAT_ID;
   logic [IdWidth-1:0]   csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic [IdWidth-1:0]   req_frame_id = '0;
   logic [7:0][7:0]      req_data = '0;
   logic                 rsp_stall = 1'b0;

   logic                       req_stall;
   logic                       rsp_valid;
   logic                       rsp_ranger_ready;
   logic                       rsp_ranger_fault;
   logic [15:0]                rsp_obstacle_distance;
   logic [7:0]                 rsp_obstacle_angle;
   logic                       rsp_obstacle_present;
   logic                       rsp_tape_present;
   logic [CountWidth-1:0]      rsp_active_sensor_count;
   logic signed [PosWidth-1:0] rsp_line_position;

   int fail_count;
   int pending_count;

   // identifiers currently loaded, used to aim random frames at the block
   logic [IdWidth-1:0] heartbeat_id = '0;
   logic [IdWidth-1:0] ranging_id = '0;
   logic [IdWidth-1:0] line_id = '0;

   int burst_left = 0;
   int stall_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   sensor_frame_decoder_line_centroid DUT (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wr_data            (csr_wr_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_frame_id           (req_frame_id),
      .req_data_byte_0        (req_data[0]),
      .req_data_byte_1        (req_data[1]),
      .req_data_byte_2        (req_data[2]),
      .req_data_byte_3        (req_data[3]),
      .req_data_byte_4        (req_data[4]),
      .req_data_byte_5        (req_data[5]),
      .req_data_byte_6        (req_data[6]),
      .req_data_byte_7        (req_data[7]),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_ranger_ready       (rsp_ranger_ready),
      .rsp_ranger_fault       (rsp_ranger_fault),
      .rsp_obstacle_distance  (rsp_obstacle_distance),
      .rsp_obstacle_angle     (rsp_obstacle_angle),
      .rsp_obstacle_present   (rsp_obstacle_present),
      .rsp_tape_present       (rsp_tape_present),
      .rsp_active_sensor_count(rsp_active_sensor_count),
      .rsp_line_position      (rsp_line_position)
   );

   sfd_status_checker status_check (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wr_data            (csr_wr_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_frame_id           (req_frame_id),
      .req_data_byte_0        (req_data[0]),
      .req_data_byte_1        (req_data[1]),
      .req_data_byte_3        (req_data[3]),
      .req_data_byte_7        (req_data[7]),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_ranger_ready       (rsp_ranger_ready),
      .rsp_ranger_fault       (rsp_ranger_fault),
      .rsp_obstacle_distance  (rsp_obstacle_distance),
      .rsp_obstacle_angle     (rsp_obstacle_angle),
      .rsp_obstacle_present   (rsp_obstacle_present),
      .rsp_tape_present       (rsp_tape_present),
      .rsp_active_sensor_count(rsp_active_sensor_count),
      .rsp_line_position      (rsp_line_position),
      .fail_count             (fail_count),
      .pending_count          (pending_count)
   );

   // Receiver stall pattern: long clear stretches, short clear runs and
   // short stalled runs, independent of rsp_valid.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_stall  <= 1'b0;
               stall_left = $urandom_range(20, 80);
            end
            1, 2: begin
               rsp_stall  <= 1'b0;
               stall_left = $urandom_range(1, 6);
            end
            default: begin
               rsp_stall  <= 1'b1;
               stall_left = $urandom_range(1, 12);
            end
         endcase
      end else begin
         stall_left--;
      end
   end

   // Frame with the used bytes given; the unused bytes carry noise.
   function automatic frame_type make_frame(input logic [IdWidth-1:0] id, input logic [7:0] b0,
                                            input logic [7:0] b1, input logic [7:0] b3,
                                            input logic [7:0] b7);
      frame_type f;
      f.id = id;
      for (int k = 0; k < 8; k++)
         f.data[k] = 8'($urandom);
      f.data[0] = b0;
      f.data[1] = b1;
      f.data[3] = b3;
      f.data[7] = b7;
      return f;
   endfunction

   // Random frame, mostly aimed at a loaded identifier so state moves.
   function automatic frame_type random_frame();
      frame_type   f;
      logic [15:0] bits;
      int          pick;
      f = make_frame(IdWidth'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
         f.id = heartbeat_id;
      end else if (pick < 54) begin
         f.id = ranging_id;
         if ($urandom_range(0, 1))
            f.data[7] = 8'd1;
      end else if (pick < 85) begin
         f.id = line_id;
         // active-low line bits: random, sparse active, or dense active
         case ($urandom_range(0, 2))
            0: bits = 16'($urandom);
            1: begin
               bits = 16'hFFFF;
               repeat ($urandom_range(1, 3)) bits[4'($urandom_range(0, 15))] = 1'b0;
            end
            default: begin
               bits = 16'h0000;
               repeat ($urandom_range(0, 3)) bits[4'($urandom_range(0, 15))] = 1'b1;
            end
         endcase
         f.data[0] = bits[7:0];
         f.data[1] = bits[15:8];
      end
      return f;
   endfunction

   // Present one item and hold it until taken; between bursts drop valid
   // so the gap really shows on the wire.
   task automatic send_frame(input frame_type f);
      req_valid    <= 1'b1;
      req_frame_id <= f.id;
      req_data     <= f.data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_random(input int count);
      repeat (count) send_frame(random_frame());
   endtask

   // Quiet the input, then wait for every predicted item plus some slack.
   task automatic wait_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Load all three identifiers, plus a write to the spare index.
   task automatic load_frame_ids(input logic [IdWidth-1:0] hb, input logic [IdWidth-1:0] rd,
                                 input logic [IdWidth-1:0] ln);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_HEARTBEAT_ID;
      csr_wr_data <= hb;
      @(posedge clock);
      csr_index   <= CSR_RANGING_ID;
      csr_wr_data <= rd;
      @(posedge clock);
      csr_index   <= CSR_LINE_ID;
      csr_wr_data <= ln;
      @(posedge clock);
      csr_index   <= CSR_SPARE_IDX;
      csr_wr_data <= ~hb;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      heartbeat_id = hb;
      ranging_id   = rd;
      line_id      = ln;
   endtask

   initial begin
      logic [IdWidth-1:0] shared_id;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset identifiers are all zero: id 0 hits heartbeat, data and line
      send_frame(make_frame('0, 8'h34, 8'h12, 8'h56, 8'd1));
      send_frame(make_frame(29'h1FFFFFFF, 8'hAA, 8'h55, 8'hAA, 8'd1));
      send_frame(make_frame('0, 8'hFE, 8'hFF, 8'h00, 8'd0));
      send_random(60);
      wait_idle();

      // distinct identifiers, directed corners first
      load_frame_ids(29'h0000100, 29'h0000101, 29'h0000102);
      send_frame(make_frame(heartbeat_id, 8'h00, 8'h00, 8'h00, 8'h00));   // fault clear
      send_frame(make_frame(heartbeat_id, 8'hFF, 8'h20, 8'hFF, 8'hFF));   // fault set
      send_frame(make_frame(29'h1FFFFFFF, 8'h00, 8'h00, 8'h00, 8'h00));   // no match, fault held
      send_frame(make_frame(ranging_id, 8'hFF, 8'hFF, 8'hFF, 8'd1));      // max distance, present
      send_frame(make_frame(ranging_id, 8'h00, 8'h00, 8'h00, 8'd0));      // zero distance
      send_frame(make_frame(ranging_id, 8'h01, 8'h80, 8'h7F, 8'hFF));     // byte 7 not one
      send_frame(make_frame(line_id, 8'hFF, 8'hFF, 8'h00, 8'h00));        // no sensor active
      send_frame(make_frame(line_id, 8'h00, 8'h00, 8'h00, 8'h00));        // all sixteen active
      send_frame(make_frame(line_id, 8'hFE, 8'hFF, 8'h00, 8'h00));        // far low edge only
      send_frame(make_frame(line_id, 8'hFF, 8'h7F, 8'h00, 8'h00));        // far high edge only
      send_frame(make_frame(line_id, 8'h00, 8'hFF, 8'h00, 8'h00));        // lower half
      send_frame(make_frame(line_id, 8'hFF, 8'h00, 8'h00, 8'h00));        // upper half
      send_frame(make_frame(line_id, 8'h5A, 8'h5A, 8'h00, 8'h00));        // scattered, zero sum
      send_frame(make_frame(line_id, 8'hFF, 8'hFE, 8'h00, 8'h00));        // just above center
      send_frame(make_frame(heartbeat_id, 8'hFF, 8'hDF, 8'hFF, 8'hFF));   // only bit 5 clear
      send_random(250);
      wait_idle();

      // identifiers at the top and bottom of their range
      load_frame_ids(29'h1FFFFFFF, 29'h1FFFFFFE, '0);
      send_random(170);
      wait_idle();

      // one identifier for all three frame kinds
      shared_id = IdWidth'($urandom);
      load_frame_ids(shared_id, shared_id, shared_id);
      send_random(120);
      wait_idle();

      // random identifiers
      load_frame_ids(IdWidth'($urandom), IdWidth'($urandom), IdWidth'($urandom));
      send_random(230);
      wait_idle();

      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sensor_frame_decoder_line_centroid.f =====
rtl/core/sfd_pkg.sv
rtl/core/sfd_divider.sv
rtl/core/sensor_frame_decoder_line_centroid.sv
tb/sfd_status_checker.sv
tb/tb_top.sv
